// ===== design/bbd_pkg.sv =====
// Shared types and constants for the bilinear Bayer demosaic block.
// No dependencies; imported by every module of the block except bbd_queue.
`default_nettype none
package bbd_pkg;

  // Fixed field widths
  localparam int OUT_W = 8;    // width of each RGB channel result
  localparam int COL_W = 11;   // column counter and reported column
  localparam int CFG_W = 12;   // line width register

  // Register map (index in the register list)
  localparam int REG_LINE_WIDTH = 0;
  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 12'd640;
  localparam int MIN_WIDTH = 3;

  // Number of complete rows needed before a window center is interior
  localparam logic [1:0] ROWS_NEEDED = 2'd2;

  // Queue sizing between front and back, and for results
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Color phase of the window center: {row odd, column odd}
  typedef enum logic [1:0] {
    PH_RED     = 2'b00,
    PH_GREEN_R = 2'b01,
    PH_GREEN_B = 2'b10,
    PH_BLUE    = 2'b11
  } phase_e;

  // Classified item handed from front to back
  typedef struct packed {
    logic [COL_W-1:0] col;      // column of the incoming sample
    logic [COL_W-1:0] pix_col;  // column of the window center
    phase_e           phase;
    logic             emit;
    logic             last;
  } item_t;

  // One result item
  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic [COL_W-1:0] col;
    logic             last;
  } res_t;

endpackage
`default_nettype wire

// ===== design/bayer_bilinear_demosaic.sv =====
// Bilinear RGGB demosaic: one raw sample in, RGB of the window center out.
// Throughput: one sample per cycle while the result queue has room for all results in flight,
// set by one line store read and one write-back per cycle.
// Border samples give no result; an interior result needs two full rows above.
// Reset clears counters, window and queues and sets line_width to 640;
// the line store is not cleared.
`default_nettype none
module bayer_bilinear_demosaic
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH   = 2048,
  parameter int SAMPLE_BITS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // sample input
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [SAMPLE_BITS-1:0] raw_sample_i,
  input  wire logic                   frame_start_i,
  // result output
  output logic                        empty,
  input  wire logic                   pop,
  output logic [OUT_W-1:0]            red_out_o,
  output logic [OUT_W-1:0]            green_out_o,
  output logic [OUT_W-1:0]            blue_out_o,
  output logic [COL_W-1:0]            pixel_col_o,
  output logic                        line_end_o
);

  localparam int FQ_W = SAMPLE_BITS + $bits(item_t);

  logic [CFG_W-1:0] line_width_q;
  logic             reg_sel;
  logic             accept;

  item_t             front_item;
  logic [FQ_W-1:0]   fq_in, fq_out;
  logic              fq_empty, fq_pop;
  item_t             fq_item;
  logic [SAMPLE_BITS-1:0] fq_sample;

  logic [QCNT_W-1:0] rq_count;
  logic              rq_push;
  res_t              rq_in, rq_out;

  // Register decode and access
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'(REG_LINE_WIDTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      line_width_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32 - CFG_W){1'b0}}, line_width_q} : '0;

  // Classify accepted samples
  assign accept = push && !full;

  bbd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_width_i  (line_width_q),
    .accept_i      (accept),
    .frame_start_i (frame_start_i),
    .item_o        (front_item)
  );

  // Queue between classification and processing
  assign fq_in = {raw_sample_i, front_item};

  bbd_queue #(
    .DW    (FQ_W),
    .DEPTH (QDEPTH)
  ) u_front_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fq_in),
    .full_o  (full),
    .pop_i   (fq_pop),
    .data_o  (fq_out),
    .empty_o (fq_empty),
    .count_o ()
  );

  assign fq_sample = fq_out[FQ_W-1 -: SAMPLE_BITS];
  assign fq_item   = item_t'(fq_out[$bits(item_t)-1:0]);

  // Line store, window and interpolation
  bbd_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_empty_i  (fq_empty),
    .in_sample_i (fq_sample),
    .in_item_i   (fq_item),
    .in_pop_o    (fq_pop),
    .out_count_i (rq_count),
    .out_push_o  (rq_push),
    .out_res_o   (rq_in)
  );

  // Result queue
  bbd_queue #(
    .DW    ($bits(res_t)),
    .DEPTH (QDEPTH)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_in),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (rq_out),
    .empty_o (empty),
    .count_o (rq_count)
  );

  assign red_out_o   = rq_out.red;
  assign green_out_o = rq_out.green;
  assign blue_out_o  = rq_out.blue;
  assign pixel_col_o = rq_out.col;
  assign line_end_o  = rq_out.last;

endmodule
`default_nettype wire

// ===== design/bbd_queue.sv =====
// Small first-in first-out queue with full, empty and fill count.
// Does not import bbd_pkg; generic width and depth.
`default_nettype none
module bbd_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [DW-1:0]                data_i,
  output logic                              full_o,
  input  wire logic                         pop_i,
  output logic [DW-1:0]                     data_o,
  output logic                              empty_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] slot_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          wr_en, rd_en;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = slot_q[rd_ptr_q];

  assign wr_en = push_i && !full_o;
  assign rd_en = pop_i && !empty_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store incoming data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/bbd_front.sv =====
// Front end: column, row parity and row fill counters; classifies each sample.
// Depends on bbd_pkg for item_t, phase_e and the width constants.
`default_nettype none
module bbd_front
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CFG_W-1:0] line_width_i,
  input  wire logic             accept_i,
  input  wire logic             frame_start_i,
  output item_t                 item_o
);

  localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
  localparam int EW      = (MW_BITS > CFG_W) ? MW_BITS : CFG_W;

  logic [COL_W-1:0] col_q, col_d;
  logic             par_q, par_d;
  logic [1:0]       rows_q, rows_d;

  logic [COL_W-1:0] col_cur;
  logic             par_cur;
  logic [1:0]       rows_cur;
  logic [EW-1:0]    width_req, width_eff;
  logic             last, emit;

  // Clamp the configured width to the supported range
  always_comb begin
    width_req = EW'(line_width_i);
    if (width_req < EW'(MIN_WIDTH)) begin
      width_eff = EW'(MIN_WIDTH);
    end else if (width_req > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = width_req;
    end
  end

  // Classify the incoming sample; frame start clears counters first
  always_comb begin
    col_cur  = frame_start_i ? '0 : col_q;
    par_cur  = frame_start_i ? 1'b0 : par_q;
    rows_cur = frame_start_i ? '0 : rows_q;

    last = (EW'(col_cur) >= (width_eff - EW'(1)));
    emit = (rows_cur == ROWS_NEEDED) && (col_cur >= COL_W'(2));

    item_o.col     = col_cur;
    item_o.pix_col = col_cur - COL_W'(1);
    item_o.phase   = phase_e'({~par_cur, ~col_cur[0]});
    item_o.emit    = emit;
    item_o.last    = last;

    col_d  = col_q;
    par_d  = par_q;
    rows_d = rows_q;
    if (accept_i) begin
      if (last) begin
        col_d  = '0;
        par_d  = ~par_cur;
        rows_d = (rows_cur == ROWS_NEEDED) ? rows_cur : rows_cur + 2'd1;
      end else begin
        col_d  = col_cur + COL_W'(1);
        par_d  = par_cur;
        rows_d = rows_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      par_q  <= 1'b0;
      rows_q <= '0;
    end else begin
      col_q  <= col_d;
      par_q  <= par_d;
      rows_q <= rows_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/bbd_back.sv =====
// Back end: two-row line store, 3x3 window and bilinear interpolation.
// Depends on bbd_pkg for item_t, res_t, phase_e and queue constants.
`default_nettype none
module bbd_back
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH   = 2048,
  parameter int SAMPLE_BITS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_empty_i,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_i,
  input  wire item_t                  in_item_i,
  output logic                        in_pop_o,
  input  wire logic [QCNT_W-1:0]      out_count_i,
  output logic                        out_push_o,
  output res_t                        out_res_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(MAX_WIDTH);

  // Line store: upper half is the older row, lower half the newer row
  logic [2*SB-1:0] store_q [MAX_WIDTH];
  logic [2*SB-1:0] rdata_q;
  logic [2*SB-1:0] byp_data_q;
  logic            byp_q, byp_d;
  logic [AW-1:0]   raddr, waddr;
  logic [2*SB-1:0] wdata, rd_word;
  logic            we;

  // Read stage
  logic             s1_valid_q;
  logic [SB-1:0]    s1_sample_q;
  item_t            s1_item_q;

  // Compute stage
  logic             s2_valid_q;
  item_t            s2_item_q;

  logic [SB-1:0]    win_q [3][3];
  logic [SB-1:0]    top, mid;

  logic [QCNT_W:0]  pending;

  logic [SB-1:0]    ctr;
  logic [SB:0]      horiz, vert;
  logic [SB+1:0]    hv, diag;

  // Pop the head when it gives no result or the result queue has room for everything in flight
  always_comb begin
    pending  = {1'b0, out_count_i}
             + (QCNT_W + 1)'(s1_valid_q && s1_item_q.emit)
             + (QCNT_W + 1)'(s2_valid_q && s2_item_q.emit);
    in_pop_o = !in_empty_i && (!in_item_i.emit || (pending < (QCNT_W + 1)'(QDEPTH)));
  end

  assign raddr = AW'(in_item_i.col);
  assign waddr = AW'(s1_item_q.col);
  assign we    = s1_valid_q;

  // Forward a write that lands on the address read in the same cycle
  assign byp_d   = in_pop_o && we && (raddr == waddr);
  assign rd_word = byp_q ? byp_data_q : rdata_q;
  assign top     = rd_word[2*SB-1:SB];
  assign mid     = rd_word[SB-1:0];
  assign wdata   = {mid, s1_sample_q};

  // Line store read and write-back
  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      rdata_q <= store_q[raddr];
    end
    if (we) begin
      store_q[waddr] <= wdata;
    end
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      s1_valid_q <= in_pop_o;
      s2_valid_q <= s1_valid_q;
      byp_q      <= byp_d;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      s1_sample_q <= in_sample_i;
      s1_item_q   <= in_item_i;
    end
    if (s1_valid_q) begin
      s2_item_q <= s1_item_q;
    end
    byp_data_q <= wdata;
  end

  // Shift the window one column per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[r][k] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= top;
      win_q[1][2] <= mid;
      win_q[2][2] <= s1_sample_q;
    end
  end

  // Neighbor sums around the center
  always_comb begin
    ctr   = win_q[1][1];
    horiz = {1'b0, win_q[1][0]} + {1'b0, win_q[1][2]};
    vert  = {1'b0, win_q[0][1]} + {1'b0, win_q[2][1]};
    hv    = {1'b0, horiz} + {1'b0, vert};
    diag  = {2'b00, win_q[0][0]} + {2'b00, win_q[0][2]}
          + {2'b00, win_q[2][0]} + {2'b00, win_q[2][2]};
  end

  // Select channels by center phase; truncating means by shift
  always_comb begin
    out_res_o.col  = s2_item_q.pix_col;
    out_res_o.last = s2_item_q.last;
    case (s2_item_q.phase)
      PH_RED: begin
        out_res_o.red   = ctr[OUT_W-1:0];
        out_res_o.green = hv[OUT_W+1:2];
        out_res_o.blue  = diag[OUT_W+1:2];
      end
      PH_GREEN_R: begin
        out_res_o.red   = horiz[OUT_W:1];
        out_res_o.green = ctr[OUT_W-1:0];
        out_res_o.blue  = vert[OUT_W:1];
      end
      PH_GREEN_B: begin
        out_res_o.red   = vert[OUT_W:1];
        out_res_o.green = ctr[OUT_W-1:0];
        out_res_o.blue  = horiz[OUT_W:1];
      end
      default: begin
        out_res_o.red   = diag[OUT_W+1:2];
        out_res_o.green = hv[OUT_W+1:2];
        out_res_o.blue  = ctr[OUT_W-1:0];
      end
    endcase
  end

  assign out_push_o = s2_valid_q && s2_item_q.emit;

endmodule
`default_nettype wire
